// File: rtl/fpa_pkg.sv
// shared types, constants and command codes for the fixed-point alu
package fpa_pkg;

	localparam int FRAC_BITS = 8;
	localparam int NUM_W = 32 + FRAC_BITS;
	localparam int IN_W = 72;
	localparam int OUT_W = 40;

	localparam logic [3:0] CMD_ADD = 4'd0;
	localparam logic [3:0] CMD_SUB = 4'd1;
	localparam logic [3:0] CMD_MUL = 4'd2;
	localparam logic [3:0] CMD_DIV = 4'd3;
	localparam logic [3:0] CMD_GT = 4'd4;
	localparam logic [3:0] CMD_LT = 4'd5;
	localparam logic [3:0] CMD_GE = 4'd6;
	localparam logic [3:0] CMD_LE = 4'd7;
	localparam logic [3:0] CMD_EQ = 4'd8;
	localparam logic [3:0] CMD_NE = 4'd9;
	localparam logic [3:0] CMD_INC = 4'd10;
	localparam logic [3:0] CMD_DEC = 4'd11;
	localparam logic [3:0] CMD_MIN = 4'd12;
	localparam logic [3:0] CMD_MAX = 4'd13;
	localparam logic [3:0] CMD_FROM_INT = 4'd14;
	localparam logic [3:0] CMD_TO_INT = 4'd15;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		logic [3:0] cmd;
		logic neg;
		logic bzero;
		logic [31:0] res;
		logic [1:0] st;
		logic cmp;
		logic [63:0] prod;
		logic [NUM_W-1:0] num;
		logic [31:0] den;
		logic [31:0] rem;
		logic [NUM_W-1:0] quo;
	} item_t;

endpackage

// File: rtl/fpa_pre.sv
// front stage: operand decode, simple commands, multiply and divider setup
module fpa_pre (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input logic [3:0] command,
	input logic signed [31:0] operand_a,
	input logic signed [31:0] operand_b,
	output logic vld_s1,
	output fpa_pkg::item_t item_s1
);
	import fpa_pkg::*;

	item_t nxt;
	logic [31:0] mag_a;
	logic [31:0] mag_b;
	logic [32:0] sum;
	logic [32:0] dif;
	logic [NUM_W-1:0] fi;
	logic [NUM_W-32:0] fi_hi;
	logic lt;
	logic eq;

	always_comb begin
		mag_a = operand_a[31] ? 32'(-operand_a) : 32'(operand_a);
		mag_b = operand_b[31] ? 32'(-operand_b) : 32'(operand_b);
		sum = {operand_a[31], operand_a} + {operand_b[31], operand_b};
		dif = {operand_a[31], operand_a} - {operand_b[31], operand_b};
		fi = NUM_W'({{FRAC_BITS{operand_a[31]}}, operand_a} << FRAC_BITS);
		fi_hi = fi[NUM_W-1:31];
		lt = operand_a < operand_b;
		eq = operand_a == operand_b;
		nxt = '0;
		nxt.cmd = command;
		nxt.neg = operand_a[31] ^ operand_b[31];
		nxt.bzero = operand_b == 32'sd0;
		nxt.prod = 64'(mag_a) * 64'(mag_b);
		nxt.num = {mag_a, {FRAC_BITS{1'b0}}};
		nxt.den = mag_b;
		nxt.st = ST_OK;
		case (command)
			CMD_ADD: begin
				nxt.res = sum[31:0];
				if (sum[32] != sum[31]) begin
					nxt.st = ST_OVF;
					nxt.res = sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
				end
			end
			CMD_SUB: begin
				nxt.res = dif[31:0];
				if (dif[32] != dif[31]) begin
					nxt.st = ST_OVF;
					nxt.res = dif[32] ? 32'h8000_0000 : 32'h7fff_ffff;
				end
			end
			CMD_GT: nxt.cmp = !lt && !eq;
			CMD_LT: nxt.cmp = lt;
			CMD_GE: nxt.cmp = !lt;
			CMD_LE: nxt.cmp = lt || eq;
			CMD_EQ: nxt.cmp = eq;
			CMD_NE: nxt.cmp = !eq;
			CMD_INC: begin
				if (operand_a == 32'sh7fff_ffff) begin
					nxt.st = ST_OVF;
					nxt.res = 32'h7fff_ffff;
				end else begin
					nxt.res = 32'(operand_a + 32'sd1);
				end
			end
			CMD_DEC: begin
				if (operand_a == 32'sh8000_0000) begin
					nxt.st = ST_OVF;
					nxt.res = 32'h8000_0000;
				end else begin
					nxt.res = 32'(operand_a - 32'sd1);
				end
			end
			CMD_MIN: nxt.res = lt ? operand_a : operand_b;
			CMD_MAX: nxt.res = lt ? operand_b : operand_a;
			CMD_FROM_INT: begin
				if (fi_hi == '0 || fi_hi == '1) begin
					nxt.res = fi[31:0];
				end else begin
					nxt.st = ST_OVF;
					nxt.res = operand_a[31] ? 32'h8000_0000 : 32'h7fff_ffff;
				end
			end
			CMD_TO_INT: nxt.res = 32'(operand_a >>> FRAC_BITS);
			default: nxt.res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt;
		end
	end

endmodule

// File: rtl/fpa_div_cell.sv
// one restoring division step: shift in a numerator bit, trial subtract
module fpa_div_cell (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input fpa_pkg::item_t item_in,
	output logic vld_q,
	output fpa_pkg::item_t item_q
);
	import fpa_pkg::*;

	item_t nxt;
	logic [32:0] trial;
	logic ge;

	always_comb begin
		nxt = item_in;
		trial = {item_in.rem, item_in.num[NUM_W-1]};
		ge = trial >= {1'b0, item_in.den};
		nxt.rem = ge ? 32'(trial - {1'b0, item_in.den}) : trial[31:0];
		nxt.num = {item_in.num[NUM_W-2:0], 1'b0};
		nxt.quo = {item_in.quo[NUM_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

endmodule

// File: rtl/fpa_post.sv
// final stage: rounding, sign, saturation and output register
module fpa_post (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input fpa_pkg::item_t item_in,
	output logic vld_q,
	output logic [31:0] result_q,
	output logic cmp_q,
	output logic [1:0] st_q
);
	import fpa_pkg::*;

	logic [63:0] mul_m;
	logic rnd;
	logic [63:0] div_m;
	logic [63:0] m;
	logic [31:0] res;
	logic [1:0] st;

	always_comb begin
		mul_m = (item_in.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		rnd = {item_in.rem, 1'b0} >= {1'b0, item_in.den};
		div_m = 64'(item_in.quo) + 64'(rnd);
		m = (item_in.cmd == CMD_MUL) ? mul_m : div_m;
		res = item_in.res;
		st = item_in.st;
		if (item_in.cmd == CMD_MUL || item_in.cmd == CMD_DIV) begin
			st = ST_OK;
			if (item_in.cmd == CMD_DIV && item_in.bzero) begin
				st = ST_DIV0;
				res = '0;
			end else if (item_in.neg) begin
				if (m > 64'h8000_0000) begin
					st = ST_OVF;
					res = 32'h8000_0000;
				end else begin
					res = 32'(-m[32:0]);
				end
			end else begin
				if (m > 64'h7fff_ffff) begin
					st = ST_OVF;
					res = 32'h7fff_ffff;
				end else begin
					res = m[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= res;
			cmp_q <= item_in.cmp;
			st_q <= st;
		end
	end

endmodule

// File: rtl/fixed_point_alu_unit.sv
// top level of the pipelined fixed-point alu
//
// channel  dir  fields (lsb first)
// s_*      in   command[3:0] operand_a[35:4] operand_b[67:36]
// m_*      out  result_value[31:0] compare_true[32] status[34:33]
//
// one transaction per cycle while the output is not stalled
// the divider is a row of NUM_W cells, one quotient bit per cell
// every command travels the whole row so results leave in order
// reset empties all stages; a stalled output freezes the whole pipeline
module fixed_point_alu_unit (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [fpa_pkg::IN_W-1:0] s_tdata,    // command, operand_a, operand_b
	output logic m_tvalid,
	input logic m_tready,
	output logic [fpa_pkg::OUT_W-1:0] m_tdata   // result_value, compare_true, status
);
	import fpa_pkg::*;

	logic en;
	logic vld_c [NUM_W+1];
	item_t item_c [NUM_W+1];
	logic [31:0] result_value;
	logic compare_true;
	logic [1:0] status;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	fpa_pre u_pre (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(s_tvalid),
		.command(s_tdata[3:0]),
		.operand_a(s_tdata[35:4]),
		.operand_b(s_tdata[67:36]),
		.vld_s1(vld_c[0]),
		.item_s1(item_c[0])
	);

	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		fpa_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_in(vld_c[i]),
			.item_in(item_c[i]),
			.vld_q(vld_c[i+1]),
			.item_q(item_c[i+1])
		);
	end

	fpa_post u_post (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_in(vld_c[NUM_W]),
		.item_in(item_c[NUM_W]),
		.vld_q(m_tvalid),
		.result_q(result_value),
		.cmp_q(compare_true),
		.st_q(status)
	);

	assign m_tdata = {5'd0, status, compare_true, result_value};

endmodule

// File: test/fixed_point_alu_unit_test.sv
// testbench for the fixed-point alu: scoreboard prediction with random stimulus and stalls
module fixed_point_alu_unit_test;
	import fpa_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic cmp;
		logic [1:0] st;
	} alu_result_t;

	localparam longint MAXV = 64'sd2147483647;
	localparam longint MINV = -64'sd2147483648;

	function automatic alu_result_t alu_predict(logic [3:0] cmd, logic [31:0] ra, logic [31:0] rb);
		longint a, b, r, ma, mb;
		longint unsigned m, num, q;
		alu_result_t res;
		a = longint'($signed(ra));
		b = longint'($signed(rb));
		r = 0;
		res = '0;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		case (cmd)
			CMD_ADD: r = a + b;
			CMD_SUB: r = a - b;
			CMD_MUL: begin
				m = longint'(ma) * longint'(mb);
				m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
				r = ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
			end
			CMD_DIV: begin
				if (b == 0) begin
					res.st = ST_DIV0;
				end else begin
					num = longint'(ma) << FRAC_BITS;
					q = (2 * num + mb) / (2 * mb);
					r = ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
				end
			end
			CMD_GT: res.cmp = a > b;
			CMD_LT: res.cmp = a < b;
			CMD_GE: res.cmp = a >= b;
			CMD_LE: res.cmp = a <= b;
			CMD_EQ: res.cmp = a == b;
			CMD_NE: res.cmp = a != b;
			CMD_INC: r = a + 1;
			CMD_DEC: r = a - 1;
			CMD_MIN: r = a < b ? a : b;
			CMD_MAX: r = a > b ? a : b;
			CMD_FROM_INT: r = a * (64'sd1 <<< FRAC_BITS);
			default: r = a >>> FRAC_BITS;
		endcase
		if (r > MAXV) begin
			r = MAXV;
			res.st = ST_OVF;
		end else if (r < MINV) begin
			r = MINV;
			res.st = ST_OVF;
		end
		res.value = r[31:0];
		return res;
	endfunction

	class alu_scoreboard;
		alu_result_t pending[$];
		int errors;

		function void note_input(logic [IN_W-1:0] d);
			pending.push_back(alu_predict(d[3:0], d[35:4], d[67:36]));
		endfunction

		function void check_result(logic [OUT_W-1:0] d);
			alu_result_t exp_r, got;
			got.value = d[31:0];
			got.cmp = d[32];
			got.st = d[34:33];
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected value %h cmp %b st %0d, got value %h cmp %b st %0d",
						exp_r.value, exp_r.cmp, exp_r.st, got.value, got.cmp, got.st);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;
	alu_scoreboard board = new();
	bit hold_off = 0;
	longint cycles = 0;

	fixed_point_alu_unit i_dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function automatic int pick_gap();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(0, 8)) - 4);
			3: return 32'($signed($urandom_range(0, 4096)) - 2048);
			4: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(logic [3:0] cmd, logic [31:0] a, logic [31:0] b, bit burst);
		int gap;
		gap = burst ? 0 : (($urandom_range(0, 3) == 0) ? 0 : pick_gap());
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {4'b0, b, a, cmd};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		board.note_input({4'b0, b, a, cmd});
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
		if (cycles > 400000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int burst_left;
		@(negedge clk);
		forever begin
			if (hold_off) begin
				m_tready <= 0;
				repeat (200) @(negedge clk);
				hold_off = 0;
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 0;
			if (burst_left > 0) begin
				m_tready <= 1;
				repeat (burst_left) @(negedge clk);
			end else if ($urandom_range(0, 15) == 0) begin
				m_tready <= 0;
				repeat (pick_gap()) @(negedge clk);
				@(negedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 3) != 0);
				@(negedge clk);
			end
		end
	end

	initial begin
		logic [31:0] edges[6];
		edges = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h00000180};
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		for (int c = 0; c < 16; c++)
			send_item(4'(c), edges[c % 6], edges[(c + 1) % 6], 0);
		send_item(CMD_DIV, 32'h100, 32'h0, 0);
		send_item(CMD_DIV, 32'h80000000, 32'hffffffff, 0);
		send_item(CMD_MUL, 32'h7fffffff, 32'h7fffffff, 0);
		send_item(CMD_MUL, 32'hffffff80, 32'h1, 0);
		send_item(CMD_DIV, 32'h1, 32'h200, 0);
		send_item(CMD_TO_INT, 32'hffffff01, 32'h0, 0);
		send_item(CMD_FROM_INT, 32'h00800000, 32'h0, 0);
		send_item(CMD_EQ, 32'h5, 32'h5, 0);
		hold_off = 1;
		for (int i = 0; i < 1650; i++)
			send_item(4'($urandom_range(0, 15)), pick_operand(), pick_operand(), i < 150);
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// File: sim.f
rtl/fpa_pkg.sv
rtl/fpa_pre.sv
rtl/fpa_div_cell.sv
rtl/fpa_post.sv
rtl/fixed_point_alu_unit.sv
test/fixed_point_alu_unit_test.sv
